// File: design/cedm_pkg.sv
// Shared types, constants and helpers for the command edit distance matcher.
`default_nettype none

package cedm_pkg;

  localparam int DEF_MAX_LEN = 32;
  localparam int DIST_W      = 6;
  localparam int LEN_W       = 6;
  localparam int CHAR_W      = 8;
  localparam int CMD_W       = 2;
  localparam int MAXD_W      = 3;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam dist_t                DIST_SAT   = dist_t'(63);
  localparam logic [MAXD_W-1:0]    MAXD_RESET = MAXD_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CAND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Data carried by the wavefront from one cell to the next.
  typedef struct packed {
    logic  valid;
    char_t ch;       // candidate character
    char_t prev_ch;  // previous candidate character
    logic  tr_ok;    // candidate already has at least one character
    dist_t col;      // new column value of the upstream cell
    dist_t diag;     // old row value of the upstream cell
    dist_t rbp_mid;  // old row-before-previous value of the upstream cell
    dist_t diag2;    // old row-before-previous value two cells upstream
    char_t qprev;    // query character of the upstream cell
  } wave_t;

  typedef struct packed {
    logic  restart;
    logic  q_wr;
    len_t  q_index;
    char_t q_char;
  } cell_ctl_t;

  function automatic dist_t sat_inc(input dist_t v);
    return (v == DIST_SAT) ? v : v + dist_t'(1);
  endfunction

  function automatic dist_t min2(input dist_t a, input dist_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: design/cedm_cell.sv
// One column cell of the distance table: holds a query character and two row values.
`default_nettype none

module cedm_cell
  import cedm_pkg::*;
#(
  parameter int IDX = 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire wave_t     wave_in,
  output wave_t          wave_out,
  output dist_t          rp_out
);

  localparam len_t  IDX_M1   = len_t'(IDX - 1);
  localparam dist_t RP_RESET = dist_t'(IDX);
  localparam logic  TR_CELL  = (IDX > 1);

  dist_t rp;
  dist_t rbp;
  char_t qc;

  dist_t sub_cost;
  dist_t best;

  always_comb begin
    sub_cost = (qc != wave_in.ch) ? sat_inc(wave_in.diag) : wave_in.diag;
    best     = min2(min2(sat_inc(rp), sat_inc(wave_in.col)), sub_cost);
    // adjacent transposition
    if (TR_CELL && wave_in.tr_ok && qc == wave_in.prev_ch && wave_in.qprev == wave_in.ch) begin
      best = min2(best, sat_inc(wave_in.diag2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      wave_out.valid <= 1'b0;
      rp             <= RP_RESET;
    end else begin
      wave_out.valid <= wave_in.valid;
      if (wave_in.valid) begin
        rp               <= best;
        rbp              <= rp;
        wave_out.ch      <= wave_in.ch;
        wave_out.prev_ch <= wave_in.prev_ch;
        wave_out.tr_ok   <= wave_in.tr_ok;
        wave_out.col     <= best;
        wave_out.diag    <= rp;
        wave_out.rbp_mid <= rbp;
        wave_out.diag2   <= wave_in.rbp_mid;
        wave_out.qprev   <= qc;
      end
    end
    if (ctl.q_wr && ctl.q_index == IDX_M1) begin
      qc <= ctl.q_char;
    end
  end

  assign rp_out = rp;

endmodule

`default_nettype wire

// File: design/command_edit_distance_matcher.sv
// Top level: query loading, candidate wavefront control and result register.
// A candidate character starts a wavefront that walks the row of MAX_LEN cells
// one cell per cycle; input stalls meanwhile. A final character also yields a result.
// Reset (synchronous): empty query, no overflow, max_distance = 2, cell rows hold
// their column index. No clearing pass.
`default_nettype none

module command_edit_distance_matcher
  import cedm_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DIST_W-1:0]      distance,
  output logic                   within_limit,
  output logic                   exact_match,
  output logic                   query_overflow,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MAXD_W-1:0] max_distance
);

  localparam int   IDX_W   = $clog2(MAX_LEN);
  localparam len_t LEN_MAX = len_t'(MAX_LEN);

  state_t state;
  state_t state_next;

  len_t              q_len;
  logic              ovf;
  dist_t             cl;
  dist_t             cl_prev;
  char_t             prev_ch;
  logic              last_r;
  logic [MAXD_W-1:0] max_limit;
  wave_t             head;

  wave_t     wave [MAX_LEN+1];
  dist_t     rp_cells [MAX_LEN];
  cell_ctl_t ctl;

  logic  in_acc;
  logic  emit_go;
  logic  done;
  cmd_t  cmd_c;
  dist_t result_d;

  assign cmd_c     = cmd_t'(cmd);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign done      = wave[MAX_LEN].valid;
  assign wave[0]   = head;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && cmd_c == CMD_CAND) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (done) state_next = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    emit_go  = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN:  in_stall = 1'b1;
      ST_EMIT: emit_go  = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    ctl.restart = emit_go ||
                  (in_acc && (cmd_c == CMD_CLEAR || cmd_c == CMD_APPEND));
    ctl.q_wr    = in_acc && cmd_c == CMD_APPEND && q_len < LEN_MAX;
    ctl.q_index = q_len;
    ctl.q_char  = char_code;
  end

  // row_previous[0] is the candidate length
  assign result_d = (q_len == len_t'(0)) ? cl
                                         : rp_cells[IDX_W'(q_len - len_t'(1))];

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    cedm_cell #(
      .IDX(g + 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wave_in  (wave[g]),
      .wave_out (wave[g+1]),
      .rp_out   (rp_cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      q_len      <= '0;
      ovf        <= 1'b0;
      cl         <= '0;
      cl_prev    <= '0;
      prev_ch    <= '0;
      last_r     <= 1'b0;
      max_limit  <= MAXD_RESET;
      head.valid <= 1'b0;
    end else begin
      state      <= state_next;
      head.valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        max_limit <= max_distance;
      end
      if (emit_go) begin
        cl      <= '0;
        prev_ch <= '0;
      end
      if (in_acc) begin
        case (cmd_c)
          CMD_CLEAR: begin
            q_len   <= '0;
            ovf     <= 1'b0;
            cl      <= '0;
            prev_ch <= '0;
          end
          CMD_APPEND: begin
            if (q_len < LEN_MAX) begin
              q_len <= q_len + len_t'(1);
            end else begin
              ovf <= 1'b1;
            end
            cl      <= '0;
            prev_ch <= '0;
          end
          CMD_CAND: begin
            head.valid   <= 1'b1;
            head.ch      <= char_code;
            head.prev_ch <= prev_ch;
            head.tr_ok   <= (cl != dist_t'(0));
            head.col     <= sat_inc(cl);
            head.diag    <= cl;
            head.rbp_mid <= cl_prev;
            head.diag2   <= cl_prev;
            head.qprev   <= char_code;
            cl_prev      <= cl;
            cl           <= sat_inc(cl);
            prev_ch      <= char_code;
            last_r       <= last;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid      <= 1'b1;
      distance       <= result_d;
      within_limit   <= (result_d <= dist_t'(max_limit));
      exact_match    <= (result_d == dist_t'(0)) && !ovf;
      query_overflow <= ovf;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> in_stall)
    else $error("input taken while wavefront is running");

  a_exact_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exact_match |-> distance == dist_t'(0) && !query_overflow)
    else $error("exact match with nonzero distance or overflow");

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    q_len <= LEN_MAX)
    else $error("query length beyond cell count");

  a_emit_after_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> $past(state) == ST_RUN || $past(state) == ST_EMIT)
    else $error("result stage entered without a wavefront");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_RUN)
    else $error("wavefront finished outside of run state");

endmodule

`default_nettype wire
